[rtl/core/fraction_sum_accumulator_defines.svh]
// ----------------------------------------------------------------------------
// fraction_sum_accumulator_defines
// assertion macros shared by the fraction sum accumulator modules; the
// module that uses them provides clk and rst_n
// ----------------------------------------------------------------------------
`ifndef FRACTION_SUM_ACCUMULATOR_DEFINES_SVH
`define FRACTION_SUM_ACCUMULATOR_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define FSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/fsa_pkg.sv]
// ----------------------------------------------------------------------------
// fsa_pkg
// types, widths and operation codes of the fraction sum accumulator
// ----------------------------------------------------------------------------
package fsa_pkg;

    localparam int NUM_W          = 64;
    localparam int DEN_W          = 63;
    localparam int FIELD_W        = 16;
    localparam int TERM_WIDTH_DEF = 16;
    localparam int ALU_W          = NUM_W + 2;

    // shared unit operations
    localparam logic [1:0] OP_DIV = 2'd0;
    localparam logic [1:0] OP_MUL = 2'd1;
    localparam logic [1:0] OP_GCD = 2'd2;

    typedef struct packed {
        logic signed [FIELD_W-1:0] term_numerator;
        logic [FIELD_W-1:0]        term_denominator;
        logic                      is_last;
    } term_word_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] sum_numerator;
        logic [DEN_W-1:0]        sum_denominator;
        logic                    zero_denominator_seen;
        logic                    overflow_seen;
    } sum_word_t;

    // accepted term, widened to the datapath
    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] numerator;
        logic [NUM_W-1:0] denominator;
        logic             is_last;
    } term_cmd_t;

    typedef struct packed {
        logic idle;
        logic emit;
    } seq_stat_t;

    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] value;
        logic             big;
    } alu_rsp_t;

endpackage

[rtl/core/fraction_sum_accumulator.sv]
// ----------------------------------------------------------------------------
// fraction_sum_accumulator
// adds a stream of fractions into one exact rational sum over the lcm of
// the denominators, and on the last term emits the fully reduced sum
// ----------------------------------------------------------------------------
//  channel  handshake                 word
//  term     term_valid / term_ready   term_numerator, term_denominator, is_last
//  result   result_valid / result_ready  sum_numerator, sum_denominator, flags
//
//  one term at a time; each term runs a gcd, a divide, a multiply, a divide
//  and two multiplies on the shared unit, which works one bit per cycle, and stops
//  early on overflow; a last term adds a gcd and two divides for the reduction
//  a term with zero denominator skips that work, but is reduced if last
//  reset clears the sum to 0/1 and both flags; no clearing pass
//  the result register holds the word while result_ready is low; the next
//  term is taken meanwhile and its own result waits for the register
// ----------------------------------------------------------------------------
module fraction_sum_accumulator #(
    parameter int TERM_WIDTH = fsa_pkg::TERM_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                term_valid,
    output logic                term_ready,
    input  fsa_pkg::term_word_t term,
    output logic                result_valid,
    input  logic                result_ready,
    output fsa_pkg::sum_word_t  result
);
    import fsa_pkg::*;

    localparam int              SHIFT    = NUM_W - TERM_WIDTH;
    localparam logic [NUM_W:0]  MASK_W   = (65'd1 << TERM_WIDTH) - 65'd1;
    localparam logic [NUM_W-1:0] DEN_MASK = MASK_W[NUM_W-1:0];

    term_cmd_t  cmd;
    seq_stat_t  stat;
    sum_word_t  seq_word;
    alu_req_t   alu_req;
    alu_rsp_t   alu_rsp;

    logic signed [NUM_W-1:0] num_sext;
    logic signed [NUM_W-1:0] num_shl;
    logic signed [NUM_W-1:0] num_term;

    logic      result_valid_reg, result_valid_next;
    sum_word_t result_reg;
    logic      out_free;

    // keep the low TERM_WIDTH bits, sign-extended numerator
    assign num_sext = {{(NUM_W-FIELD_W){term.term_numerator[FIELD_W-1]}},
                       term.term_numerator};
    assign num_shl  = num_sext <<< SHIFT;
    assign num_term = num_shl >>> SHIFT;

    assign term_ready      = stat.idle;
    assign cmd.go          = term_valid && stat.idle;
    assign cmd.numerator   = num_term;
    assign cmd.denominator = {{(NUM_W-FIELD_W){1'b0}}, term.term_denominator} & DEN_MASK;
    assign cmd.is_last     = term.is_last;

    fsa_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .out_free    (out_free),
        .stat        (stat),
        .result_word (seq_word),
        .req         (alu_req),
        .rsp         (alu_rsp)
    );

    fsa_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // output register
    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (stat.emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.emit)
        begin
            result_reg <= seq_word;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/core/fsa_alu.sv]
// ----------------------------------------------------------------------------
// fsa_alu
// shared bit-serial unit: restoring divide, shift-add multiply with overflow
// detect, and binary gcd, all on one 66-bit add/subtract path
// ----------------------------------------------------------------------------
`include "fraction_sum_accumulator_defines.svh"

module fsa_alu (
    input  logic              clk,
    input  logic              rst_n,
    input  fsa_pkg::alu_req_t req,
    output fsa_pkg::alu_rsp_t rsp
);
    import fsa_pkg::*;

    localparam logic [1:0] PH_TWO  = 2'd0;
    localparam logic [1:0] PH_LOOP = 2'd1;
    localparam logic [1:0] PH_SHL  = 2'd2;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             big_reg, big_next;
    logic [1:0]       op_reg, op_next;
    logic [1:0]       phase_reg, phase_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [NUM_W-1:0] x_reg, x_next;
    logic [NUM_W-1:0] y_reg, y_next;
    logic [NUM_W-1:0] z_reg, z_next;
    logic [NUM_W-1:0] res_reg, res_next;

    logic [ALU_W-1:0] opa;
    logic [ALU_W-1:0] opb;
    logic             sub;
    logic [ALU_W-1:0] sum;
    logic             gcd_ge;
    logic             gcd_zero;

    // operand select for the shared adder
    assign gcd_ge   = (x_reg >= y_reg);
    assign gcd_zero = (x_reg == '0) || (y_reg == '0);

    always_comb
    begin
        case (op_reg)
            OP_DIV:
            begin
                opa = {1'b0, x_reg, y_reg[NUM_W-1]};
                opb = {2'b00, z_reg};
                sub = 1'b1;
            end
            OP_MUL:
            begin
                opa = {1'b0, x_reg, 1'b0};
                opb = y_reg[NUM_W-1] ? {2'b00, z_reg} : '0;
                sub = 1'b0;
            end
            default:
            begin
                opa = gcd_ge ? {2'b00, x_reg} : {2'b00, y_reg};
                opb = gcd_ge ? {2'b00, y_reg} : {2'b00, x_reg};
                sub = 1'b1;
            end
        endcase
        sum = opa + (opb ^ {ALU_W{sub}}) + {{(ALU_W-1){1'b0}}, sub};
    end

    // iteration control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        big_next   = big_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        res_next   = res_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next  = 1'b1;
                big_next   = 1'b0;
                op_next    = req.op;
                phase_next = PH_TWO;
                unique case (req.op)
                    OP_DIV:
                    begin
                        x_next   = '0;
                        y_next   = req.a;
                        z_next   = req.b;
                        cnt_next = '1;
                    end
                    OP_MUL:
                    begin
                        x_next   = '0;
                        y_next   = req.b;
                        z_next   = req.a;
                        cnt_next = '1;
                    end
                    OP_GCD:
                    begin
                        x_next   = req.a;
                        y_next   = req.b;
                        cnt_next = '0;
                    end
                    default:
                    begin
                        busy_next = 1'b0;
                    end
                endcase
            end
        end
        else
        begin
            case (op_reg)
                OP_DIV:
                begin
                    // keep the shifted remainder when the subtract borrows
                    if (!sum[ALU_W-1])
                    begin
                        x_next = sum[NUM_W-1:0];
                        y_next = {y_reg[NUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        x_next = opa[NUM_W-1:0];
                        y_next = {y_reg[NUM_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = y_next;
                    end
                end
                OP_MUL:
                begin
                    // msb-first shift-add, sticky flag once past 64 bits
                    x_next   = sum[NUM_W-1:0];
                    big_next = big_reg | sum[ALU_W-1] | sum[ALU_W-2];
                    y_next   = {y_reg[NUM_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 6'd1;
                    if (cnt_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                        res_next  = x_next;
                    end
                end
                default:
                begin
                    unique case (phase_reg)
                        PH_TWO:
                        begin
                            // strip common factors of two, counted in cnt
                            if (gcd_zero)
                            begin
                                x_next     = x_reg | y_reg;
                                phase_next = PH_SHL;
                            end
                            else if (!x_reg[0] && !y_reg[0])
                            begin
                                x_next   = x_reg >> 1;
                                y_next   = y_reg >> 1;
                                cnt_next = cnt_reg + 6'd1;
                            end
                            else
                            begin
                                phase_next = PH_LOOP;
                            end
                        end
                        PH_LOOP:
                        begin
                            if (gcd_zero)
                            begin
                                x_next     = x_reg | y_reg;
                                phase_next = PH_SHL;
                            end
                            else if (!x_reg[0])
                            begin
                                x_next = x_reg >> 1;
                            end
                            else if (!y_reg[0])
                            begin
                                y_next = y_reg >> 1;
                            end
                            else if (gcd_ge)
                            begin
                                x_next = sum[NUM_W-1:0];
                            end
                            else
                            begin
                                y_next = sum[NUM_W-1:0];
                            end
                        end
                        PH_SHL:
                        begin
                            // restore the common factors of two
                            if (cnt_reg == '0)
                            begin
                                busy_next = 1'b0;
                                done_next = 1'b1;
                                res_next  = x_reg;
                            end
                            else
                            begin
                                x_next   = x_reg << 1;
                                cnt_next = cnt_reg - 6'd1;
                            end
                        end
                        default:
                        begin
                            busy_next = 1'b0;
                            done_next = 1'b1;
                            res_next  = x_reg;
                        end
                    endcase
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        big_reg   <= big_next;
        op_reg    <= op_next;
        phase_reg <= phase_next;
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        res_reg   <= res_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.value = res_reg;
    assign rsp.big   = big_reg;

    `FSA_ASSERT_SAME(a_start_when_free, req.start, !busy_reg, "alu started while busy")
    `FSA_ASSERT_SAME(a_done_frees_unit, done_reg, !busy_reg, "alu done while still busy")
    `FSA_ASSERT_SAME(a_div_nonzero, req.start && (req.op == OP_DIV), req.b != '0,
                     "alu divide by zero")

endmodule

[rtl/core/fsa_seq.sv]
// ----------------------------------------------------------------------------
// fsa_seq
// sequencer and running rational sum: drives the shared unit through lcm,
// scaling and overflow checks per term, then the final reduction
// ----------------------------------------------------------------------------
`include "fraction_sum_accumulator_defines.svh"

module fsa_seq (
    input  logic               clk,
    input  logic               rst_n,
    input  fsa_pkg::term_cmd_t cmd,
    input  logic               out_free,
    output fsa_pkg::seq_stat_t stat,
    output fsa_pkg::sum_word_t result_word,
    output fsa_pkg::alu_req_t  req,
    input  fsa_pkg::alu_rsp_t  rsp
);
    import fsa_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GCD   = 4'd1;
    localparam logic [3:0] S_DIVQ1 = 4'd2;
    localparam logic [3:0] S_MULL  = 4'd3;
    localparam logic [3:0] S_DIVQ2 = 4'd4;
    localparam logic [3:0] S_MULA  = 4'd5;
    localparam logic [3:0] S_MULB  = 4'd6;
    localparam logic [3:0] S_END   = 4'd7;
    localparam logic [3:0] S_RGCD  = 4'd8;
    localparam logic [3:0] S_RNUM  = 4'd9;
    localparam logic [3:0] S_RDEN  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]       state_reg, state_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] den_reg, den_next;
    logic             zf_reg, zf_next;
    logic             of_reg, of_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic [NUM_W-1:0] d_reg, d_next;
    logic             last_reg, last_next;
    logic [NUM_W-1:0] g_reg, g_next;
    logic [NUM_W-1:0] q1_reg, q1_next;
    logic [NUM_W-1:0] l_reg, l_next;
    logic [NUM_W-1:0] a_reg, a_next;
    logic [NUM_W-1:0] qn_reg, qn_next;
    logic [NUM_W-1:0] qd_reg, qd_next;

    logic [NUM_W-1:0] mag_num;
    logic [NUM_W-1:0] mag_n;
    logic [NUM_W-1:0] prod_neg;
    logic             over_pos;
    logic             over_neg;
    logic             bad_a;
    logic             bad_b;
    logic [NUM_W-1:0] a_val;
    logic [NUM_W-1:0] b_val;
    logic [NUM_W-1:0] s_val;
    logic             s_ovf;
    logic [NUM_W-1:0] g_fix;
    logic [NUM_W-1:0] qd_pick;

    // magnitudes, product range checks and the signed sum of the two terms
    assign mag_num  = num_reg[NUM_W-1] ? (~num_reg + 64'd1) : num_reg;
    assign mag_n    = n_reg[NUM_W-1] ? (~n_reg + 64'd1) : n_reg;
    assign prod_neg = ~rsp.value + 64'd1;
    assign over_pos = rsp.big | rsp.value[NUM_W-1];
    assign over_neg = rsp.big | (rsp.value[NUM_W-1] & (|rsp.value[NUM_W-2:0]));
    assign bad_a    = num_reg[NUM_W-1] ? over_neg : over_pos;
    assign bad_b    = n_reg[NUM_W-1] ? over_neg : over_pos;
    assign a_val    = num_reg[NUM_W-1] ? prod_neg : rsp.value;
    assign b_val    = n_reg[NUM_W-1] ? prod_neg : rsp.value;
    assign s_val    = a_reg + b_val;
    assign s_ovf    = ~(a_reg[NUM_W-1] ^ b_val[NUM_W-1]) & (a_reg[NUM_W-1] ^ s_val[NUM_W-1]);
    assign g_fix    = (rsp.value == '0) ? 64'd1 : rsp.value;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        zf_next    = zf_reg;
        of_next    = of_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        last_next  = last_reg;
        g_next     = g_reg;
        q1_next    = q1_reg;
        l_next     = l_reg;
        a_next     = a_reg;
        qn_next    = qn_reg;
        qd_next    = qd_reg;
        req.start  = 1'b0;
        req.op     = OP_DIV;
        req.a      = '0;
        req.b      = '0;
        stat.idle  = (state_reg == S_IDLE);
        stat.emit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.go)
                begin
                    n_next    = cmd.numerator;
                    d_next    = cmd.denominator;
                    last_next = cmd.is_last;
                    if (cmd.denominator == '0)
                    begin
                        zf_next    = 1'b1;
                        state_next = S_END;
                    end
                    else
                    begin
                        req.start  = 1'b1;
                        req.op     = OP_GCD;
                        req.a      = den_reg;
                        req.b      = cmd.denominator;
                        state_next = S_GCD;
                    end
                end
            end
            S_GCD:
            begin
                if (rsp.done)
                begin
                    g_next     = rsp.value;
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    req.a      = den_reg;
                    req.b      = rsp.value;
                    state_next = S_DIVQ1;
                end
            end
            S_DIVQ1:
            begin
                // q1 = D / g, also the scale of the new term
                if (rsp.done)
                begin
                    q1_next    = rsp.value;
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = rsp.value;
                    req.b      = d_reg;
                    state_next = S_MULL;
                end
            end
            S_MULL:
            begin
                // common denominator must stay below 2^63
                if (rsp.done)
                begin
                    if (over_pos)
                    begin
                        of_next    = 1'b1;
                        state_next = S_END;
                    end
                    else
                    begin
                        l_next     = rsp.value;
                        req.start  = 1'b1;
                        req.op     = OP_DIV;
                        req.a      = d_reg;
                        req.b      = g_reg;
                        state_next = S_DIVQ2;
                    end
                end
            end
            S_DIVQ2:
            begin
                if (rsp.done)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_MUL;
                    req.a      = mag_num;
                    req.b      = rsp.value;
                    state_next = S_MULA;
                end
            end
            S_MULA:
            begin
                if (rsp.done)
                begin
                    if (bad_a)
                    begin
                        of_next    = 1'b1;
                        state_next = S_END;
                    end
                    else
                    begin
                        a_next     = a_val;
                        req.start  = 1'b1;
                        req.op     = OP_MUL;
                        req.a      = mag_n;
                        req.b      = q1_reg;
                        state_next = S_MULB;
                    end
                end
            end
            S_MULB:
            begin
                if (rsp.done)
                begin
                    if (bad_b || s_ovf)
                    begin
                        of_next = 1'b1;
                    end
                    else
                    begin
                        num_next = s_val;
                        den_next = l_reg;
                    end
                    state_next = S_END;
                end
            end
            S_END:
            begin
                if (last_reg)
                begin
                    req.start  = 1'b1;
                    req.op     = OP_GCD;
                    req.a      = mag_num;
                    req.b      = den_reg;
                    state_next = S_RGCD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RGCD:
            begin
                if (rsp.done)
                begin
                    g_next     = g_fix;
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    req.a      = mag_num;
                    req.b      = g_fix;
                    state_next = S_RNUM;
                end
            end
            S_RNUM:
            begin
                if (rsp.done)
                begin
                    qn_next    = rsp.value;
                    req.start  = 1'b1;
                    req.op     = OP_DIV;
                    req.a      = den_reg;
                    req.b      = g_reg;
                    state_next = S_RDEN;
                end
            end
            S_RDEN:
            begin
                if (rsp.done)
                begin
                    qd_next    = rsp.value;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hand over the reduced sum and start a fresh one
                if (out_free)
                begin
                    stat.emit  = 1'b1;
                    num_next   = '0;
                    den_next   = 64'd1;
                    zf_next    = 1'b0;
                    of_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // reduced result, zero sum shown as 0/1
    assign qd_pick = (qn_reg == '0) ? 64'd1 : qd_reg;
    assign result_word.sum_numerator         = num_reg[NUM_W-1] ? (~qn_reg + 64'd1) : qn_reg;
    assign result_word.sum_denominator       = qd_pick[DEN_W-1:0];
    assign result_word.zero_denominator_seen = zf_reg;
    assign result_word.overflow_seen         = of_reg;

    // running sum and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_reg   <= '0;
            den_reg   <= 64'd1;
            zf_reg    <= 1'b0;
            of_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
            den_reg   <= den_next;
            zf_reg    <= zf_next;
            of_reg    <= of_next;
        end
    end

    // per-term working registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        last_reg <= last_next;
        g_reg    <= g_next;
        q1_reg   <= q1_next;
        l_reg    <= l_next;
        a_reg    <= a_next;
        qn_reg   <= qn_next;
        qd_reg   <= qd_next;
    end

    `FSA_ASSERT_SAME(a_done_in_wait, rsp.done,
                     (state_reg != S_IDLE) && (state_reg != S_END) && (state_reg != S_OUT),
                     "alu result arrived while no operation was pending")
    `FSA_ASSERT_NEXT(a_clear_after_emit, stat.emit,
                     (num_reg == '0) && (den_reg == 64'd1) && !zf_reg && !of_reg,
                     "sum not cleared after emit")
    `FSA_ASSERT_SAME(a_den_nonzero, 1'b1, den_reg != '0, "running denominator is zero")

endmodule

[bench/fraction_sum_accumulator_test.sv]
// ----------------------------------------------------------------------------
// fraction_sum_accumulator_test
// self-checking bench for the fraction sum accumulator: a short table of
// hand-picked terms, then random sequences of fractions of several flavors,
// each accepted term folded into an exact rational model whose reduced sums
// are compared word by word with the result channel
// ----------------------------------------------------------------------------
module fraction_sum_accumulator_test;
    import fsa_pkg::*;

    localparam int ITEM_TARGET  = 1900;
    localparam int CALM_TAIL    = 300;
    localparam int PHASE_LEN    = 200;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 1000;

    localparam bit [NUM_W-1:0] NUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam bit [NUM_W-1:0] NUM_MIN = 64'h8000_0000_0000_0000;

    typedef enum {SEQ_PLAIN, SEQ_WIDE, SEQ_HEAVY} seq_kind_t;

    typedef struct {
        term_word_t word;
        bit         typed;
        sum_word_t  want;
    } plan_row_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       term_valid   = 1'b0;
    logic       term_ready;
    term_word_t term         = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    sum_word_t  result;

    // running sum of the model
    bit [NUM_W-1:0] acc_num      = '0;
    bit [NUM_W-1:0] acc_den      = 64'd1;
    bit             acc_zero_den = 1'b0;
    bit             acc_overflow = 1'b0;

    sum_word_t expected_sums[$];
    sum_word_t oldest_sum;
    plan_row_t directed_rows[$];

    bit idling_on   = 1'b0;
    int stall_left  = 0;
    int idle_cycles = 0;
    int mismatches  = 0;
    int items_sent  = 0;

    fraction_sum_accumulator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .term_valid   (term_valid),
        .term_ready   (term_ready),
        .term         (term),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #4 clk = ~clk;

    function automatic bit [NUM_W-1:0] euclid(bit [NUM_W-1:0] a, bit [NUM_W-1:0] b);
        bit [NUM_W-1:0] r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    // signed value times unsigned factor, flags a product outside 64 bits
    function automatic bit [NUM_W-1:0] scale_signed(bit [NUM_W-1:0] v, bit [NUM_W-1:0] m,
                                                    inout bit bad);
        bit             neg;
        bit [NUM_W-1:0] mag;
        bit [NUM_W-1:0] lim;
        bit [NUM_W-1:0] p;
        neg = v[NUM_W-1];
        mag = neg ? -v : v;
        lim = neg ? NUM_MIN : NUM_MAX;
        if (m != 0 && mag > lim / m)
        begin
            bad = 1'b1;
            return '0;
        end
        p = mag * m;
        return neg ? -p : p;
    endfunction

    // fold one term into the running sum; a last term yields the reduced sum
    task automatic fold_term(input term_word_t w, output bit emits, output sum_word_t s);
        bit [NUM_W-1:0] n;
        bit [NUM_W-1:0] d;
        bit [NUM_W-1:0] g;
        bit [NUM_W-1:0] lcm_mult;
        bit [NUM_W-1:0] l;
        bit [NUM_W-1:0] a;
        bit [NUM_W-1:0] b;
        bit [NUM_W-1:0] total;
        bit [NUM_W-1:0] mag;
        bit [NUM_W-1:0] qn;
        bit [NUM_W-1:0] qd;
        bit             bad;
        bit             neg;
        n   = {{(NUM_W-FIELD_W){w.term_numerator[FIELD_W-1]}}, w.term_numerator};
        d   = NUM_W'(w.term_denominator);
        bad = 1'b0;
        s   = '0;
        // zero denominator skips the term
        if (d == 0)
        begin
            acc_zero_den = 1'b1;
        end
        else
        begin
            g        = euclid(acc_den, d);
            lcm_mult = acc_den / g;
            // common denominator out of range skips the term
            if (lcm_mult > NUM_MAX / d)
            begin
                acc_overflow = 1'b1;
            end
            else
            begin
                l     = lcm_mult * d;
                a     = scale_signed(acc_num, l / acc_den, bad);
                b     = scale_signed(n, l / d, bad);
                total = a + b;
                if (a[NUM_W-1] == b[NUM_W-1] && a[NUM_W-1] != total[NUM_W-1])
                    bad = 1'b1;
                if (bad)
                begin
                    acc_overflow = 1'b1;
                end
                else
                begin
                    acc_num = total;
                    acc_den = l;
                end
            end
        end
        emits = w.is_last;
        if (emits)
        begin
            // full reduction, zero sum comes out as 0/1
            neg = acc_num[NUM_W-1];
            mag = neg ? -acc_num : acc_num;
            g   = euclid(mag, acc_den);
            if (g == 0)
                g = 1;
            qn = mag / g;
            qd = acc_den / g;
            if (qn == 0)
                qd = 1;
            s.sum_numerator         = neg ? -qn : qn;
            s.sum_denominator       = qd[DEN_W-1:0];
            s.zero_denominator_seen = acc_zero_den;
            s.overflow_seen         = acc_overflow;
            acc_num      = '0;
            acc_den      = 64'd1;
            acc_zero_den = 1'b0;
            acc_overflow = 1'b0;
        end
    endtask

    task automatic add_row(input int num, input int den, input bit last,
                           input bit typed = 1'b0, input longint want_num = 0,
                           input longint want_den = 1, input bit want_zero = 1'b0);
        plan_row_t r;
        r.word.term_numerator         = num[FIELD_W-1:0];
        r.word.term_denominator       = den[FIELD_W-1:0];
        r.word.is_last                = last;
        r.typed                       = typed;
        r.want.sum_numerator          = want_num;
        r.want.sum_denominator        = want_den[DEN_W-1:0];
        r.want.zero_denominator_seen  = want_zero;
        r.want.overflow_seen          = 1'b0;
        directed_rows.push_back(r);
    endtask

    function automatic term_word_t random_term(seq_kind_t kind, bit last);
        term_word_t w;
        int         pick;
        w.is_last = last;
        pick      = $urandom_range(0, 99);
        if (kind == SEQ_HEAVY)
        begin
            // extreme numerators against unit or big denominators to push the sum wide
            case ($urandom_range(0, 2))
                0:       w.term_numerator = 16'sh7FFF;
                1:       w.term_numerator = 16'sh8000;
                default: w.term_numerator = FIELD_W'($urandom);
            endcase
            w.term_denominator = (pick < 50) ? 16'd1 : FIELD_W'($urandom_range(32768, 65535));
        end
        else
        begin
            if ($urandom_range(0, 1))
                w.term_numerator = FIELD_W'($urandom);
            else
                w.term_numerator = FIELD_W'(int'($urandom_range(0, 40)) - 20);
            if (kind == SEQ_WIDE)
                w.term_denominator = (pick < 5) ? 16'd0 : FIELD_W'($urandom);
            else if (pick < 3)
                w.term_denominator = 16'd0;
            else if (pick < 50)
                w.term_denominator = FIELD_W'($urandom_range(1, 12));
            else if (pick < 85)
                w.term_denominator = FIELD_W'($urandom_range(1, 255));
            else
                w.term_denominator = FIELD_W'($urandom);
        end
        return w;
    endfunction

    // present one word, hold it until taken, then record what it should yield
    task automatic send_term(input term_word_t w, input bit typed, input sum_word_t want);
        bit        emits;
        sum_word_t predicted;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            term_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        term_valid <= 1'b1;
        term       <= w;
        do @(posedge clk); while (!term_ready);
        fold_term(w, emits, predicted);
        if (emits)
            expected_sums.push_back(typed ? want : predicted);
    endtask

    // result side: check each taken word, stall in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $error("unexpected result word %h", result);
                    mismatches++;
                end
                else
                begin
                    oldest_sum = expected_sums.pop_front();
                    if (result.sum_numerator !== oldest_sum.sum_numerator)
                    begin
                        $error("sum_numerator: expected %0d, got %0d",
                               oldest_sum.sum_numerator, result.sum_numerator);
                        mismatches++;
                    end
                    if (result.sum_denominator !== oldest_sum.sum_denominator)
                    begin
                        $error("sum_denominator: expected %0d, got %0d",
                               oldest_sum.sum_denominator, result.sum_denominator);
                        mismatches++;
                    end
                    if (result.zero_denominator_seen !== oldest_sum.zero_denominator_seen)
                    begin
                        $error("zero_denominator_seen: expected %0b, got %0b",
                               oldest_sum.zero_denominator_seen,
                               result.zero_denominator_seen);
                        mismatches++;
                    end
                    if (result.overflow_seen !== oldest_sum.overflow_seen)
                    begin
                        $error("overflow_seen: expected %0b, got %0b",
                               oldest_sum.overflow_seen, result.overflow_seen);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 7) - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if ((term_valid && term_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        seq_kind_t kind;
        int        len;
        int        pick;

        // single terms with sums readable at a glance
        add_row(0, 1, 1'b1, 1'b1, 0, 1);
        add_row(1, 0, 1'b1, 1'b1, 0, 1, 1'b1);
        add_row(-32768, 1, 1'b1, 1'b1, -32768, 1);
        add_row(32767, 1, 1'b1, 1'b1, 32767, 1);
        add_row(32767, 65535, 1'b1, 1'b1, 32767, 65535);
        add_row(4, 8, 1'b1, 1'b1, 1, 2);
        // opposite terms cancel to zero, then 1/2 plus 1/3 gives 5/6
        add_row(1, 65535, 1'b0);
        add_row(-1, 65535, 1'b1, 1'b1, 0, 1);
        add_row(1, 2, 1'b0);
        add_row(1, 3, 1'b1, 1'b1, 5, 6);
        // skipped zero-denominator term, then a normal one
        add_row(3, 0, 1'b0);
        add_row(1, 4, 1'b1, 1'b1, 1, 4, 1'b1);
        // large sum over a growing denominator: numerator overflow
        repeat (4) add_row(32767, 1, 1'b0);
        add_row(32767, 65535, 1'b0);
        add_row(32767, 65534, 1'b0);
        add_row(32767, 65533, 1'b0);
        add_row(-1, 65531, 1'b1);
        // coprime denominators until the common one no longer fits
        add_row(1, 65535, 1'b0);
        add_row(1, 65534, 1'b0);
        add_row(1, 65533, 1'b0);
        add_row(1, 65531, 1'b0);
        add_row(1, 65521, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        idling_on = 1'b1;
        foreach (directed_rows[i])
        begin
            send_term(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
            items_sent++;
        end

        // random sequences, idling in alternating phases, calm at the end
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                kind = SEQ_PLAIN;
                len  = $urandom_range(1, 6);
            end
            else if (pick < 88)
            begin
                kind = SEQ_WIDE;
                len  = $urandom_range(2, 6);
            end
            else
            begin
                kind = SEQ_HEAVY;
                len  = $urandom_range(3, 8);
            end
            for (int k = 0; k < len; k++)
            begin
                idling_on = (items_sent < ITEM_TARGET - CALM_TAIL)
                            && ((items_sent / PHASE_LEN) % 2 == 0);
                send_term(random_term(kind, k == len - 1), 1'b0, '0);
                items_sent++;
            end
        end

        term_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
